// ----- hdl/gmim_pkg.sv -----
// ----------------------------------------------------------------------------
// gmim_pkg: shared types and constants for the increasing-moves grid engine
// Sizes of the line store, position counters and the front/back item queue.
// ----------------------------------------------------------------------------
package gmim_pkg;

    // grid limits and field widths
    localparam int MAX_ROWS   = 1024;
    localparam int MAX_COLS   = 1024;
    localparam int VALUE_BITS = 20;
    localparam int ROW_BITS   = $clog2(MAX_ROWS);
    localparam int COL_BITS   = $clog2(MAX_COLS);
    localparam int CFG_BITS   = 11;

    // item queue between front and back; depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [ROW_BITS-1:0]   t_row;
    typedef logic [COL_BITS-1:0]   t_col;

    // one classified cell, as handed from front to back
    typedef struct packed {
        t_value value;
        t_row   row;
        t_col   col;
        logic   first_col;  // column 0: always reachable
        logic   has_upper;  // row above exists in this column
        logic   has_lower;  // row below exists in this column
        logic   last;       // final cell of the grid
    } t_item;

    // one line-store entry
    typedef struct packed {
        logic   reach;
        t_value value;
    } t_line;

endpackage

// ----- hdl/gmim_front.sv -----
// ----------------------------------------------------------------------------
// gmim_front: input side of the increasing-moves grid engine
// Holds the row count register, tracks the row and column of the next cell
// and tags each accepted cell with its position and neighbor flags.
// ----------------------------------------------------------------------------
module gmim_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [gmim_pkg::CFG_BITS-1:0] i_cfg_wdata,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [gmim_pkg::VALUE_BITS-1:0] i_cell_value,
    input  logic                    i_last_cell,
    output logic                    o_push,
    output gmim_pkg::t_item         o_item,
    input  logic                    i_q_space
);
    import gmim_pkg::*;

    logic [CFG_BITS-1:0] r_row_count;
    t_row                r_row, n_row;
    t_col                r_col, n_col;
    logic [ROW_BITS:0]   rows_eff;
    logic [ROW_BITS:0]   row_plus;
    logic                last_row;
    logic                xfer;

    assign o_ready = i_q_space;
    assign xfer    = i_valid & i_q_space;
    assign o_push  = xfer;

    // effective row count: zero reads as one, large counts saturate
    always_comb begin
        if (r_row_count == '0) begin
            rows_eff = (ROW_BITS+1)'(1);
        end else if (32'(r_row_count) > MAX_ROWS) begin
            rows_eff = (ROW_BITS+1)'(MAX_ROWS);
        end else begin
            rows_eff = (ROW_BITS+1)'(r_row_count);
        end
    end

    assign row_plus = {1'b0, r_row} + (ROW_BITS+1)'(1);
    assign last_row = (row_plus >= rows_eff);

    // classified item
    always_comb begin
        o_item.value     = i_cell_value;
        o_item.row       = r_row;
        o_item.col       = r_col;
        o_item.first_col = (r_col == '0);
        o_item.has_upper = (r_row != '0);
        o_item.has_lower = ~last_row;
        o_item.last      = i_last_cell;
    end

    // next position
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (xfer) begin
            if (i_last_cell) begin
                n_row = '0;
                n_col = '0;
            end else if (last_row) begin
                n_row = '0;
                if (r_col != COL_BITS'(MAX_COLS - 1)) begin
                    n_col = r_col + COL_BITS'(1);
                end
            end else begin
                n_row = row_plus[ROW_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CFG_BITS'(1);
            r_row       <= '0;
            r_col       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_row_count <= i_cfg_wdata;
            end
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

// ----- hdl/gmim_queue.sv -----
// ----------------------------------------------------------------------------
// gmim_queue: short item queue between front and back
// Small register FIFO; the head entry is visible while the queue is not empty.
// ----------------------------------------------------------------------------
module gmim_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gmim_pkg::t_item i_push_item,
    output logic            o_space,
    output logic            o_pop_valid,
    output gmim_pkg::t_item o_pop_item,
    input  logic            i_pop
);
    import gmim_pkg::*;

    t_item                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_space     = (r_count != (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_item  = r_mem[r_rd_ptr];
    assign do_push     = i_push & o_space;
    assign do_pop      = i_pop & o_pop_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QPTR_BITS+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_BITS+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ----- hdl/gmim_back.sv -----
// ----------------------------------------------------------------------------
// gmim_back: line store and reachability datapath
// Reads the previous column's entries for the cell's row and the row below,
// decides reachability, writes the cell back and keeps the best column.
// ----------------------------------------------------------------------------
module gmim_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  gmim_pkg::t_item i_q_item,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [gmim_pkg::COL_BITS-1:0] o_max_moves
);
    import gmim_pkg::*;

    // line store: one write port, two registered read ports
    t_line mem [MAX_ROWS];
    t_line r_rd0, r_rd1;

    // execute stage
    logic  r_s2_valid;
    t_item r_s2;
    logic  r_hit0, r_hit1;
    t_line r_byp;

    // saved entry of the row above, and running best column
    t_value r_up_val;
    logic   r_up_reach;
    t_col   r_best;

    // output register
    logic r_out_valid;
    t_col r_out_moves;

    logic  out_free;
    logic  s2_fire;
    logic  s2_load;
    t_row  rd_addr0, rd_addr1;
    t_line old0, old1, wr_data;
    logic  s2_reach;
    t_col  best_now;

    assign out_free = ~r_out_valid | i_ready;
    assign s2_fire  = r_s2_valid & (~r_s2.last | out_free);
    assign s2_load  = i_q_valid & (~r_s2_valid | s2_fire);
    assign o_q_pop  = s2_load;

    assign rd_addr0 = i_q_item.row;
    assign rd_addr1 = i_q_item.row + ROW_BITS'(1);

    // read data, with the write of the same edge forwarded
    assign old0 = r_hit0 ? r_byp : r_rd0;
    assign old1 = r_hit1 ? r_byp : r_rd1;

    // reachable in column 0, or from left, upper-left or lower-left
    always_comb begin
        s2_reach = r_s2.first_col
                 | (old0.reach & (old0.value < r_s2.value))
                 | (r_s2.has_upper & r_up_reach & (r_up_val < r_s2.value))
                 | (r_s2.has_lower & old1.reach & (old1.value < r_s2.value));
    end

    assign wr_data.reach = s2_reach;
    assign wr_data.value = r_s2.value;
    assign best_now      = s2_reach ? r_s2.col : r_best;

    // line store access
    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            mem[r_s2.row] <= wr_data;
        end
        if (s2_load) begin
            r_rd0 <= mem[rd_addr0];
            r_rd1 <= mem[rd_addr1];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_up_reach  <= 1'b0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s2_load) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_up_reach <= old0.reach;
                r_best     <= r_s2.last ? '0 : best_now;
            end
            if (s2_fire & r_s2.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_s2   <= i_q_item;
            r_hit0 <= s2_fire & (r_s2.row == rd_addr0);
            r_hit1 <= s2_fire & (r_s2.row == rd_addr1);
            r_byp  <= wr_data;
        end
        if (s2_fire) begin
            r_up_val <= old0.value;
        end
        if (s2_fire & r_s2.last) begin
            r_out_moves <= best_now;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_max_moves = r_out_moves;

    // a result appears only after a final cell went through
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s2_fire & r_s2.last))
        else $error("result without a final cell");

    // the best column restarts after each grid
    a_best_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire & r_s2.last |=> r_best == '0)
        else $error("best column not cleared after grid");

    // column 0 cells are always reachable
    a_first_col_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire & r_s2.first_col |-> s2_reach)
        else $error("column 0 cell marked unreachable");

    // a stalled cell holds its place
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid & ~s2_fire |=> r_s2_valid & $stable(r_s2))
        else $error("stalled cell lost");

endmodule

// ----- hdl/grid_max_increasing_moves.sv -----
// ----------------------------------------------------------------------------
// grid_max_increasing_moves: longest rightward strictly increasing path
// Streams grid cells column by column, top row first, and reports the largest
// column reachable from column 0 by moves to strictly larger neighbors.
//
// Usage:
//   Set the rows per column through i_cfg_we / i_cfg_wdata while no grid is
//   in flight (reset value 1; zero acts as 1, counts above 1024 saturate).
//   Cells arrive on the i_valid / o_ready channel, one transfer per cell, with
//   i_last_cell high on the final cell. One result per grid leaves on the
//   o_valid / i_ready channel as o_max_moves.
//   Throughput: one cell per cycle while o_ready stays high, set by the
//   two-read, one-write line store that holds the previous column. The final
//   cell passes through the queue, execute stage and output register before o_valid.
//   A stalled receiver holds the result; cells keep flowing until the next
//   final cell reaches the back end, then the 4-entry queue fills and o_ready
//   drops. Reset clears position, best column and all valid flags; the line
//   store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module grid_max_increasing_moves (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [gmim_pkg::CFG_BITS-1:0] i_cfg_wdata,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [gmim_pkg::VALUE_BITS-1:0] i_cell_value,
    input  logic                    i_last_cell,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [gmim_pkg::COL_BITS-1:0] o_max_moves
);
    import gmim_pkg::*;

    logic  push;
    t_item push_item;
    logic  q_space;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    // position tracking and classification
    gmim_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cell_value (i_cell_value),
        .i_last_cell  (i_last_cell),
        .o_push       (push),
        .o_item       (push_item),
        .i_q_space    (q_space)
    );

    // decoupling queue
    gmim_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_space     (q_space),
        .o_pop_valid (q_valid),
        .o_pop_item  (q_item),
        .i_pop       (q_pop)
    );

    // line store, reachability and result
    gmim_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_max_moves (o_max_moves)
    );

endmodule

// ----- bench/grid_max_increasing_moves_tb.sv -----
// ----------------------------------------------------------------------------
// grid_max_increasing_moves_tb: self-checking bench for the grid move engine
// Streams grids of cells through the valid/ready input, predicts the largest
// reachable column of each grid with a line-store model of its own, and
// compares every result transfer in order. Idling on both channels, one long
// receiver stall, row counts from zero to above the store depth, a mid-grid
// row count change and the column-count saturation are all covered.
// ----------------------------------------------------------------------------

// Predicts max_moves per grid and holds the results still to come
class moves_scoreboard;
    gmim_pkg::t_value            line_vals [gmim_pkg::MAX_ROWS];
    bit                          line_reach[gmim_pkg::MAX_ROWS];
    int unsigned                 row_pos;
    int unsigned                 col_pos;
    gmim_pkg::t_value            above_val;
    bit                          above_reach;
    int unsigned                 best_col;
    logic [gmim_pkg::CFG_BITS-1:0] row_setting;
    gmim_pkg::t_col              moves_q[$];
    int unsigned                 errors;

    function new();
        foreach (line_vals[i]) begin
            line_vals[i]  = '0;
            line_reach[i] = 1'b0;
        end
        row_setting = 1;
        errors      = 0;
        restart();
    endfunction

    function void restart();
        row_pos     = 0;
        col_pos     = 0;
        above_val   = '0;
        above_reach = 1'b0;
        best_col    = 0;
    endfunction

    function void set_rows(logic [gmim_pkg::CFG_BITS-1:0] n);
        row_setting = n;
    endfunction

    // one accepted cell: update the line store, queue a result on the last cell
    function void note_cell(gmim_pkg::t_value v, bit last);
        int unsigned      rows;
        int unsigned      r;
        bit               reach;
        gmim_pkg::t_value old_v;
        bit               old_r;
        rows = (row_setting == 0) ? 1 :
               (row_setting > gmim_pkg::MAX_ROWS) ? gmim_pkg::MAX_ROWS : row_setting;
        r = (row_pos >= gmim_pkg::MAX_ROWS) ? gmim_pkg::MAX_ROWS - 1 : row_pos;
        old_v = line_vals[r];
        old_r = line_reach[r];

        // column 0 is always a start; later cells need a smaller reached neighbor
        if (col_pos == 0) begin
            reach = 1'b1;
        end else begin
            reach = old_r && (old_v < v);
            if (r > 0 && above_reach && above_val < v)
                reach = 1'b1;
            if (r + 1 < rows && r + 1 < gmim_pkg::MAX_ROWS) begin
                if (line_reach[r+1] && line_vals[r+1] < v)
                    reach = 1'b1;
            end
        end

        above_val     = old_v;
        above_reach   = old_r;
        line_vals[r]  = v;
        line_reach[r] = reach;
        if (reach)
            best_col = col_pos;

        if (last) begin
            moves_q.push_back(gmim_pkg::t_col'(best_col));
            restart();
        end else if (r + 1 >= rows) begin
            row_pos = 0;
            if (col_pos < gmim_pkg::MAX_COLS - 1)
                col_pos++;
            above_val   = '0;
            above_reach = 1'b0;
        end else begin
            row_pos = r + 1;
        end
    endfunction

    // one result transfer against the oldest prediction
    function void check_moves(gmim_pkg::t_col actual);
        gmim_pkg::t_col exp_moves;
        if (moves_q.size() == 0) begin
            $display("%0t: unexpected max_moves, expected none, actual %0d",
                     $time, actual);
            errors++;
        end else begin
            exp_moves = moves_q.pop_front();
            if (exp_moves !== actual) begin
                $display("%0t: max_moves mismatch, expected %0d, actual %0d",
                         $time, exp_moves, actual);
                errors++;
            end
        end
    endfunction
endclass

module grid_max_increasing_moves_tb;
    import gmim_pkg::*;

    logic                i_clk;
    logic                i_rst_n      = 1'b0;
    logic                i_cfg_we     = 1'b0;
    logic [CFG_BITS-1:0] i_cfg_wdata  = '0;
    logic                i_valid      = 1'b0;
    logic                o_ready;
    t_value              i_cell_value = '0;
    logic                i_last_cell  = 1'b0;
    logic                o_valid;
    logic                i_ready      = 1'b0;
    t_col                o_max_moves;

    moves_scoreboard     sb = new();

    int                  send_idle_pct = 38;
    int                  recv_idle_pct = 60;
    logic                stall_req     = 1'b0;
    logic                stall_taken   = 1'b0;
    int                  stall_left    = 0;
    logic [CFG_BITS-1:0] rows_set      = 1;
    int                  rand_cells    = 0;

    grid_max_increasing_moves uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cell_value(i_cell_value),
        .i_last_cell (i_last_cell),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_max_moves (o_max_moves)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // receiver: random ready, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (stall_req && !stall_taken) begin
            stall_left  <= 400;
            stall_taken <= 1'b1;
            i_ready     <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // observe config writes and transfers on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.set_rows(i_cfg_wdata);
            if (i_valid && o_ready)
                sb.note_cell(i_cell_value, i_last_cell);
            if (o_valid && i_ready)
                sb.check_moves(o_max_moves);
        end
    end

    function automatic int rows_in_use();
        if (rows_set == 0)
            return 1;
        if (rows_set > MAX_ROWS)
            return MAX_ROWS;
        return rows_set;
    endfunction

    function automatic void set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endfunction

    // offer one cell and hold it until the transfer
    task automatic send_cell(t_value v, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cell_value <= v;
        i_last_cell  <= last;
        do
            @(posedge i_clk);
        while (!o_ready);
    endtask

    // row count write once all results are in and the pipe has emptied
    task automatic write_rows(logic [CFG_BITS-1:0] n);
        i_valid <= 1'b0;
        while (sb.moves_q.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n;
        rows_set    = n;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // one grid: climbing columns with jitter, or plain noise
    task automatic send_grid(int cells, bit climb);
        int     rows;
        int     base0;
        int     step;
        int     spread;
        int     col;
        t_value v;
        rows   = rows_in_use();
        base0  = $urandom_range(1, 1 << 19);
        step   = $urandom_range(0, 64);
        spread = $urandom_range(1, 128);
        for (int i = 0; i < cells; i++) begin
            col = i / rows;
            if (climb)
                v = t_value'(base0 + col * step + $urandom_range(0, spread));
            else
                v = t_value'($urandom_range(1, (1 << VALUE_BITS) - 1));
            send_cell(v, i == cells - 1);
        end
    endtask

    initial begin
        int rsel;
        int ngrids;
        int cols;
        int cells;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default of one row; strictly larger moves, then a drop
        send_cell(20'd5, 1'b0);
        send_cell(20'd7, 1'b0);
        send_cell(20'd6, 1'b1);

        // zero rows acts as one; value extremes
        write_rows(0);
        send_cell(20'd1, 1'b0);
        send_cell(20'hFFFFF, 1'b1);

        // three rows: reach via lower-left only, upper-left only, none;
        // grid ends inside column 2
        write_rows(3);
        send_cell(20'd30, 1'b0);
        send_cell(20'd10, 1'b0);
        send_cell(20'd20, 1'b0);
        send_cell(20'd15, 1'b0);
        send_cell(20'd5,  1'b0);
        send_cell(20'd15, 1'b0);
        send_cell(20'd16, 1'b0);
        send_cell(20'd6,  1'b1);

        // equal values do not count as a move
        write_rows(1);
        send_cell(20'd8, 1'b0);
        send_cell(20'd8, 1'b1);

        // row count lowered at a column boundary in mid-grid
        write_rows(2);
        send_cell(20'd1, 1'b0);
        send_cell(20'd2, 1'b0);
        send_cell(20'd3, 1'b0);
        send_cell(20'd4, 1'b0);
        write_rows(1);
        send_cell(20'd5, 1'b0);
        send_cell(20'd6, 1'b1);

        // full store depth, short grid
        write_rows(CFG_BITS'(MAX_ROWS));
        send_grid(5, 1'b0);

        // count above store depth saturates: short grid inside column 0
        write_rows('1);
        send_grid(6, 1'b0);

        // single row, more columns than the counter holds
        write_rows(1);
        for (int i = 0; i < MAX_COLS + 6; i++)
            send_cell(t_value'(i * 1000 + $urandom_range(1, 999)), i == MAX_COLS + 5);

        // random grids in segments of one row count each
        while (rand_cells < 200 || !stall_req) begin
            if (rand_cells < 67)
                set_idling(38, 60);
            else if (rand_cells < 134)
                set_idling(60, 38);
            else
                set_idling(0, 0);

            rsel = $urandom_range(99);
            if (rsel < 8)
                write_rows(0);
            else if (rsel < 75)
                write_rows(CFG_BITS'($urandom_range(1, 6)));
            else
                write_rows(CFG_BITS'($urandom_range(7, 16)));

            ngrids = $urandom_range(1, 4);
            if (!stall_req && rand_cells >= 80) begin
                stall_req <= 1'b1;
                ngrids    = 4;
            end

            for (int g = 0; g < ngrids; g++) begin
                cols  = ($urandom_range(99) < 5) ? 12 : $urandom_range(1, 6);
                cells = cols * rows_in_use();
                if ($urandom_range(99) < 30)
                    cells = $urandom_range(1, cells);
                send_grid(cells, $urandom_range(99) < 70);
                rand_cells += cells;
            end
        end

        // drain and let the pipe settle
        i_valid <= 1'b0;
        while (sb.moves_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.moves_q.size() == 0)
            $display("grid_max_increasing_moves test passed");
        else
            $display("grid_max_increasing_moves test failed");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("grid_max_increasing_moves test failed");
        $finish;
    end

endmodule
